/* hw/rtl/art_pkg.sv */
// art_pkg: shared constants and types for the address region table.
// Used by the channel interfaces, the top level, the region RAM and the checker.
`default_nettype none

package art_pkg;

  // Default table depth
  localparam int MAX_REGIONS_DEF = 16;

  // Field widths
  localparam int ADDR_W   = 48;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_ZERO_ARG  = 2'd3
  } status_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } region_t;

endpackage

`default_nettype wire

/* hw/rtl/art_if.sv */
// art_req_if / art_rsp_if: valid-ready channels of the address region table.
// Depends on art_pkg for field widths.
`default_nettype none

interface art_req_if;
  import art_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   region_base;
  logic [ADDR_W-1:0]   region_size;
  logic [SLOT_W-1:0]   slot_index;
  logic [ADDR_W-1:0]   lookup_address;

  modport source (
    output valid, action, region_base, region_size, slot_index, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, action, region_base, region_size, slot_index, lookup_address,
    output ready
  );
endinterface

interface art_rsp_if;
  import art_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   assigned_slot;
  logic                hit;

  modport source (
    output valid, status, assigned_slot, hit,
    input  ready
  );
  modport sink (
    input  valid, status, assigned_slot, hit,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/art_region_ram.sv */
// art_region_ram: one-write, one-read synchronous RAM of region entries.
// Read data is registered. Depends on art_pkg.
`default_nettype none

module art_region_ram #(
  parameter int DEPTH = art_pkg::MAX_REGIONS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  art_pkg::region_t     wdata,
  input  logic [IDX_W-1:0]     raddr,
  output art_pkg::region_t     rdata
);
  import art_pkg::*;

  region_t mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/address_region_table.sv */
// address_region_table: table of address regions with add, delete and lookup.
// Depends on art_pkg, art_req_if / art_rsp_if and art_region_ram.
//
//  channel | modport | direction | carries
//  --------+---------+-----------+-------------------------------------------------
//  req     | sink    | in        | action, region_base, region_size, slot_index,
//          |         |           | lookup_address
//  rsp     | source  | out       | status, assigned_slot, hit
//
// One transaction at a time. Delete, add with a zero argument and unused action go
// from idle straight to done. Add: a downward scan from the count, testing one slot
// valid bit per cycle, takes the highest free slot; with none, it appends or reports full.
// Lookup: reads the slots below the count, the RAM read port delivering one entry
// per cycle; it ends at the first hit.
// Reset clears the per-slot valid bits and the count at once; no clearing pass.
// A new request is taken while the previous response still waits in the
// output register; a finished result holds until that register frees up.
`default_nettype none

module address_region_table #(
  parameter int MAX_REGIONS = art_pkg::MAX_REGIONS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  art_req_if.sink   req,
  art_rsp_if.source rsp
);
  import art_pkg::*;

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_LOOK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t               state;
  logic [MAX_REGIONS-1:0] slot_valid;
  logic [CNT_W-1:0]     used_count;
  logic [CNT_W-1:0]     cur;        // add scan pointer / lookup issue pointer

  // latched request
  logic [ADDR_W-1:0]    it_base;
  logic [ADDR_W-1:0]    it_size;
  logic [ADDR_W-1:0]    it_addr;

  // pending result
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_hit;

  // lookup read pipeline
  logic                 pend;
  logic                 pend_vld;
  logic                 pend_last;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  region_t              mem_wdata;
  region_t              mem_rdata;
  logic [CNT_W-1:0]     cur_m1;
  logic                 free_here;
  logic                 is_full;
  logic                 issue;
  logic [ADDR_W:0]      region_end;
  logic                 hit_now;
  logic                 del_bad;

  assign req.ready = (state == S_IDLE);

  // add scan: slot below the pointer, free when its valid bit is clear
  assign cur_m1    = cur - 1'b1;
  assign free_here = !slot_valid[cur_m1[IDX_W-1:0]];
  assign is_full   = (used_count == CNT_MAX);

  // RAM write on a successful add, either at the found slot or appended
  assign mem_we    = (state == S_ADD) && ((cur != '0) ? free_here : !is_full);
  assign mem_waddr = (cur != '0) ? cur_m1[IDX_W-1:0] : used_count[IDX_W-1:0];
  assign mem_wdata = '{base: it_base, size: it_size};

  // lookup: one entry read per cycle below the count
  assign issue      = (state == S_LOOK) && (cur < used_count);
  assign region_end = {1'b0, mem_rdata.base} + {1'b0, mem_rdata.size};
  assign hit_now    = pend && pend_vld && (it_addr >= mem_rdata.base) &&
                      ({1'b0, it_addr} < region_end);

  assign del_bad = (32'(req.slot_index) >= MAX_REGIONS);

  art_region_ram #(
    .DEPTH (MAX_REGIONS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cur[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      used_count <= '0;
      pend       <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      pend      <= issue;
      pend_vld  <= slot_valid[cur[IDX_W-1:0]];
      pend_last <= (CNT_W'(cur + 1'b1) == used_count);

      // response taken; S_DONE reloads it itself
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            it_base    <= req.region_base;
            it_size    <= req.region_size;
            it_addr    <= req.lookup_address;
            res_slot   <= '0;
            res_hit    <= 1'b0;
            case (req.action)
              ACT_ADD: begin
                if (req.region_base == '0 || req.region_size == '0) begin
                  res_status <= ST_ZERO_ARG;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  cur        <= used_count;
                  state      <= S_ADD;
                end
              end
              ACT_DELETE: begin
                if (del_bad) begin
                  res_status <= ST_BAD_INDEX;
                end else begin
                  res_status <= ST_OK;
                  slot_valid[IDX_W'(req.slot_index)] <= 1'b0;
                end
                state <= S_DONE;
              end
              ACT_LOOKUP: begin
                res_status <= ST_OK;
                cur        <= '0;
                state      <= (used_count == '0) ? S_DONE : S_LOOK;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_ADD: begin
          if (cur == '0) begin
            // no free slot below the count: append or report full
            if (is_full) begin
              res_status <= ST_FULL;
            end else begin
              slot_valid[used_count[IDX_W-1:0]] <= 1'b1;
              used_count <= used_count + 1'b1;
              res_slot   <= SLOT_W'(used_count);
            end
            state <= S_DONE;
          end else if (free_here) begin
            slot_valid[cur_m1[IDX_W-1:0]] <= 1'b1;
            res_slot <= SLOT_W'(cur_m1);
            state    <= S_DONE;
          end else begin
            cur <= cur_m1;
          end
        end

        S_LOOK: begin
          if (issue) begin
            cur <= cur + 1'b1;
          end
          if (hit_now) begin
            res_hit <= 1'b1;
            state   <= S_DONE;
          end else if (pend && pend_last) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response payload register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status        <= res_status;
      rsp.assigned_slot <= res_slot;
      rsp.hit           <= res_hit;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/art_checker.sv */
// art_checker: port-level assertions on the address region table response.
// Depends on art_pkg; bound to address_region_table at the end of this file.
`default_nettype none

module art_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [art_pkg::STATUS_W-1:0] rsp_status,
  input logic [art_pkg::SLOT_W-1:0]   rsp_slot,
  input logic                         rsp_hit
);
  import art_pkg::*;

  // no response right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a stalled response stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // a stalled response keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_hit))
    else $error("response payload changed while stalled");

  // an error response carries no slot and no hit
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_slot == '0 && !rsp_hit)
    else $error("error response with slot or hit set");

  // a hit comes only with a lookup, which never assigns a slot
  a_hit_noslot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> rsp_slot == '0)
    else $error("hit response with a slot set");

endmodule

bind address_region_table art_checker u_art_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_slot   (rsp.assigned_slot),
  .rsp_hit    (rsp.hit)
);

`default_nettype wire

/* tb/sv/art_region_ledger.sv */
`timescale 1ns / 1ps
// art_region_ledger_pkg: request/response records and the region ledger class
// that predicts each response of the address region table and checks it. Depends on art_pkg.

package art_region_ledger_pkg;
  import art_pkg::*;

  // One request transaction as offered on the req channel
  typedef struct {
    action_t           action;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_size;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] lookup_address;
  } art_request_t;

  // One response transaction as seen on the rsp channel
  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] assigned_slot;
    logic              hit;
  } art_response_t;

  class region_ledger;
    int unsigned       depth;
    logic [ADDR_W-1:0] base_tab[];
    logic [ADDR_W-1:0] size_tab[];
    int unsigned       high_water;
    art_response_t     awaited_replies[$];
    int unsigned       mismatches;

    function new(int unsigned table_depth);
      depth = table_depth;
      base_tab = new[depth];
      size_tab = new[depth];
      foreach (base_tab[i]) begin
        base_tab[i] = '0;
        size_tab[i] = '0;
      end
      high_water = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited_replies.size();
    endfunction

    // Apply an accepted request to the shadow table and queue its response
    function void note_request(art_request_t rq);
      art_response_t     r;
      int unsigned       span;
      int unsigned       pick;
      int                i;
      logic [ADDR_W:0]   region_end;
      r.status = ST_OK;
      r.assigned_slot = '0;
      r.hit = 1'b0;
      span = (high_water > depth) ? depth : high_water;
      case (rq.action)
        ACT_ADD: begin
          if (rq.region_base == '0 || rq.region_size == '0) begin
            r.status = ST_ZERO_ARG;
          end else begin
            // highest free slot below the count, else append
            pick = span;
            for (i = int'(span) - 1; i >= 0; i--) begin
              if (base_tab[i] == '0) begin
                pick = i;
                break;
              end
            end
            if (pick >= depth) begin
              r.status = ST_FULL;
            end else begin
              base_tab[pick] = rq.region_base;
              size_tab[pick] = rq.region_size;
              if (pick >= span) high_water = pick + 1;
              r.assigned_slot = SLOT_W'(pick);
            end
          end
        end
        ACT_DELETE: begin
          if (rq.slot_index >= depth) begin
            r.status = ST_BAD_INDEX;
          end else begin
            base_tab[rq.slot_index] = '0;
            size_tab[rq.slot_index] = '0;
          end
        end
        ACT_LOOKUP: begin
          // inclusive base, exclusive end, end computed without wrap
          for (i = 0; i < int'(span); i++) begin
            region_end = {1'b0, base_tab[i]} + {1'b0, size_tab[i]};
            if (base_tab[i] != '0 && size_tab[i] != '0 &&
                base_tab[i] <= rq.lookup_address &&
                {1'b0, rq.lookup_address} < region_end) begin
              r.hit = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      awaited_replies.push_back(r);
    endfunction

    // Compare a response with the oldest expectation, field by field
    function void check_reply(art_response_t got);
      art_response_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: response with none expected: status=%0d slot=%0d hit=%0d",
                 $time, got.status, got.assigned_slot, got.hit);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.assigned_slot !== want.assigned_slot) begin
        mismatches++;
        $display("%0t: assigned_slot expected %0d, got %0d",
                 $time, want.assigned_slot, got.assigned_slot);
      end
      if (got.hit !== want.hit) begin
        mismatches++;
        $display("%0t: hit expected %0d, got %0d", $time, want.hit, got.hit);
      end
    endfunction
  endclass

endpackage

/* tb/sv/address_region_table_test.sv */
`timescale 1ns / 1ps
// address_region_table_test: drives add, delete and lookup transactions into the
// region table with random stalls on both channels and checks every response.
// Depends on art_pkg, art_req_if / art_rsp_if, art_region_ledger_pkg and the RTL.

module address_region_table_test;
  import art_pkg::*;
  import art_region_ledger_pkg::*;

  localparam int DEPTH        = MAX_REGIONS_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 90;
  localparam int HOLD_AT      = 200;
  localparam int DRAIN_AT     = 320;
  localparam int CALM_FROM    = 420;
  localparam int CALM_TO      = 520;
  localparam int SETTLE       = DEPTH + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  art_req_if req ();
  art_rsp_if rsp ();

  address_region_table #(.MAX_REGIONS(DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #4 clk = ~clk;

  region_ledger ledger;
  int unsigned  sent;

  // Window with no idling on either side
  function automatic bit calm();
    return sent >= CALM_FROM && sent < CALM_TO;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic art_request_t request_of(action_t a, logic [ADDR_W-1:0] b,
                                              logic [ADDR_W-1:0] s, logic [SLOT_W-1:0] k,
                                              logic [ADDR_W-1:0] addr);
    art_request_t rq;
    rq.action = a;
    rq.region_base = b;
    rq.region_size = s;
    rq.slot_index = k;
    rq.lookup_address = addr;
    return rq;
  endfunction

  // Random slot that currently holds a region, -1 if none
  function automatic int used_slot();
    int start;
    int k;
    start = $urandom_range(DEPTH - 1);
    for (k = 0; k < DEPTH; k++) begin
      if (ledger.base_tab[(start + k) % DEPTH] != '0) return (start + k) % DEPTH;
    end
    return -1;
  endfunction

  // Offer one transaction, with an optional idle gap first; returns at acceptance
  task automatic offer(input art_request_t rq);
    if (!calm() && $urandom_range(99) < 29) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.action         <= rq.action;
    req.region_base    <= rq.region_base;
    req.region_size    <= rq.region_size;
    req.slot_index     <= rq.slot_index;
    req.lookup_address <= rq.lookup_address;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    ledger.note_request(rq);
    sent++;
  endtask

  // Response side: random back-pressure, one long hold, one calm window
  initial begin : rsp_sink
    bit held_once;
    held_once = 1'b0;
    rsp.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!held_once && sent >= HOLD_AT) begin
        held_once = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        rsp.ready <= calm() ? 1'b1 : ($urandom_range(99) >= 29);
        @(posedge clk);
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    art_response_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = status_t'(rsp.status);
      got.assigned_slot = rsp.assigned_slot;
      got.hit = rsp.hit;
      ledger.check_reply(got);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    art_request_t      rq;
    int                n;
    int                j;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W:0]   region_end;
    ledger = new(DEPTH);
    sent = 0;
    req.valid = 1'b0;
    req.action = ACT_NONE;
    req.region_base = '0;
    req.region_size = '0;
    req.slot_index = '0;
    req.lookup_address = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused action, zero arguments, top of space, fill up
    offer(request_of(ACT_LOOKUP, '0, '0, '0, '0));
    offer(request_of(ACT_NONE, '1, '1, '1, '1));
    offer(request_of(ACT_ADD, '0, 48'h10, '0, '0));
    offer(request_of(ACT_ADD, 48'h1000, '0, '0, '0));
    offer(request_of(ACT_ADD, '1, '1, '0, '0));           // end runs past 48 bits
    offer(request_of(ACT_LOOKUP, '0, '0, '0, '1));
    offer(request_of(ACT_LOOKUP, '0, '0, '0, 48'hFFFF_FFFF_FFFE));
    offer(request_of(ACT_DELETE, '0, '0, 4'd15, '0));     // slot never used
    for (n = 1; n < DEPTH; n++) begin
      offer(request_of(ACT_ADD, ADDR_W'(n) << 12, 48'h800, '0, '0));
    end
    offer(request_of(ACT_ADD, 48'h5000_0000, 48'h10, '0, '0));  // table full
    offer(request_of(ACT_DELETE, '0, '0, 4'd0, '0));

    // Random traffic
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) begin
        req.valid <= 1'b0;
        do @(posedge clk); while (ledger.pending() != 0);
      end
      rq = request_of(ACT_NONE, rand48(), rand48(), SLOT_W'($urandom()), rand48());
      j = $urandom_range(99);
      if (j < 36) begin
        rq.action = ACT_ADD;
        case ($urandom_range(9))
          0: rq.region_base = '0;
          1: rq.region_size = '0;
          2, 3: ;                                    // wide random region
          4: rq.region_base = '1;
          5: rq.region_size = '1;
          default: begin
            rq.region_base = ADDR_W'($urandom_range(1, 4095)) << 4;
            rq.region_size = ADDR_W'($urandom_range(1, 512));
          end
        endcase
      end else if (j < 60) begin
        rq.action = ACT_DELETE;
        if ($urandom_range(9) < 7 && used_slot() >= 0) rq.slot_index = SLOT_W'(used_slot());
      end else if (j < 96) begin
        rq.action = ACT_LOOKUP;
        j = used_slot();
        if (j >= 0 && $urandom_range(9) < 6) begin
          // probe around the bounds of a stored region
          b = ledger.base_tab[j];
          s = ledger.size_tab[j];
          region_end = {1'b0, b} + {1'b0, s};
          case ($urandom_range(4))
            0: rq.lookup_address = b;
            1: rq.lookup_address = b - 1'b1;
            2: rq.lookup_address = region_end[ADDR_W] ? '1 : region_end[ADDR_W-1:0] - 1'b1;
            3: rq.lookup_address = region_end[ADDR_W-1:0];
            default: rq.lookup_address = b + (rand48() % s);
          endcase
        end else if ($urandom_range(1)) begin
          rq.lookup_address = ADDR_W'($urandom_range(0, 70000));
        end
      end
      offer(rq);
    end
    req.valid <= 1'b0;

    // Wait out the remaining responses, then give the block time to misbehave
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* address_region_table.f */
hw/rtl/art_pkg.sv
hw/rtl/art_if.sv
hw/rtl/art_region_ram.sv
hw/rtl/address_region_table.sv
hw/rtl/art_checker.sv
tb/sv/art_region_ledger.sv
tb/sv/address_region_table_test.sv
